FILE: rtl/vertex_transform_perspective_divide_assert.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define VTPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define VTPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/vtpd_pkg.sv
// Package with shared constants and types of the vertex transform.
`default_nettype none
package vtpd_pkg;
  // Fixed-point format: saturation width of the quotients and fraction bits.
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS = 16;
  // Column sums stay below 2**48 in magnitude, so 50 signed bits hold them.
  localparam int unsigned SumW = 50;
  localparam int unsigned MagW = 49;
  localparam int unsigned QuoW = COORD_WIDTH;
  localparam logic ActLoad = 1'b0;
  localparam logic ActXform = 1'b1;

  // Division state of one point that travels together down the divider chain.
  // The quo field starts with the low dividend bits and fills with quotient bits.
  typedef struct packed {
    logic                 wz;
    logic [2:0]           neg;
    logic [2:0]           sat;
    logic [2:0][MagW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
    logic [MagW-1:0]      den;
  } div_word_t;
endpackage
`default_nettype wire

FILE: rtl/vertex_transform_perspective_divide.sv
// Top level of the 4x4 vertex transform with perspective divide.
// Usage: one input channel (in_valid_i/in_stall_o) carries words; action 0
// loads one matrix row, action 1 transforms a point (x,y,z,1).
// One output channel (out_valid_o/out_stall_i) returns one word per point:
// x'/w', y'/w', z'/w' saturated to 32 bits, plus w_zero and clipped flags.
// Throughput: one word per cycle while the pipe is not held. A point passes from
// the accepting edge to out_valid_o through the product register, the column-sum
// register and the divider setup register, then a chain of 32 division cells (one
// quotient bit each), then the output register. Load words produce no output word.
// The whole pipe advances together; when the receiver stalls and the output
// register is full, the pipe holds and in_stall_o rises in the same cycle.
// Reset restores the identity matrix and empties the pipe.
// The matrix rows are flip-flops; a load takes effect for the next word.
`default_nettype none
module vertex_transform_perspective_divide (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [1:0]  row_i,
  input  wire logic signed [31:0] v0_i,
  input  wire logic signed [31:0] v1_i,
  input  wire logic signed [31:0] v2_i,
  input  wire logic signed [31:0] v3_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic             w_zero_o,
  output logic             clipped_o
);
  import vtpd_pkg::*;
`include "vertex_transform_perspective_divide_assert.svh"

  localparam int unsigned NCells = QuoW;
  localparam logic [QuoW-1:0] PosLim = QuoW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [QuoW-1:0] NegLim = QuoW'(64'd1 << (COORD_WIDTH - 1));

  logic adv;
  logic signed [31:0] m_q [16];
  logic s1_vld_q;
  logic signed [63:0] p_q [4][3];
  logic signed [31:0] t_q [4];
  logic s2_vld_q;
  logic signed [SumW-1:0] sum_q [4];
  logic [MagW-1:0] mag [4];
  div_word_t setup_d;
  logic s3_vld_q;
  div_word_t s3_q;
  logic [NCells:0] vld_chain;
  div_word_t chain [NCells+1];
  logic [QuoW-1:0] lim [3];
  logic [QuoW-1:0] qq [3];
  logic [2:0] cl;
  logic [QuoW-1:0] res [3];
  logic ov_q, oz_q, oc_q;
  logic signed [31:0] ox_q, oy_q, ozz_q;

  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Matrix storage, written by load words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? 32'(1 << FRAC_BITS) : '0;
    end else if (in_valid_i && adv && action_i == ActLoad) begin
      m_q[{row_i, 2'd0}] <= v0_i;
      m_q[{row_i, 2'd1}] <= v1_i;
      m_q[{row_i, 2'd2}] <= v2_i;
      m_q[{row_i, 2'd3}] <= v3_i;
    end
  end

  // Stage 1: twelve products, one multiplier each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= in_valid_i && action_i == ActXform;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        p_q[c][0] <= v0_i * m_q[c];
        p_q[c][1] <= v1_i * m_q[4 + c];
        p_q[c][2] <= v2_i * m_q[8 + c];
        t_q[c] <= m_q[12 + c];
      end
    end
  end

  // Stage 2: floor shift and column sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SumW'(p_q[c][0] >>> FRAC_BITS) + SumW'(p_q[c][1] >>> FRAC_BITS)
                  + SumW'(p_q[c][2] >>> FRAC_BITS) + SumW'(t_q[c]);
      end
    end
  end

  // Divider setup: magnitudes and signs. A quotient that needs more than
  // QuoW bits, and every quotient of a zero w, saturates right here.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = sum_q[c][SumW-1] ? MagW'(-sum_q[c]) : MagW'(sum_q[c]);
    end
    setup_d = '0;
    setup_d.wz = (sum_q[3] == '0);
    setup_d.den = mag[3];
    for (int l = 0; l < 3; l++) begin
      setup_d.sat[l] = (mag[l] >> (QuoW - FRAC_BITS)) >= mag[3];
      setup_d.neg[l] = setup_d.wz ? sum_q[l][SumW-1]
                                  : (sum_q[l][SumW-1] ^ sum_q[3][SumW-1]);
      setup_d.rem[l] = setup_d.sat[l] ? '0 : (mag[l] >> (QuoW - FRAC_BITS));
      setup_d.quo[l] = {mag[l][QuoW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // Stage 3: setup register feeding the first division cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (adv) s3_vld_q <= s2_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) s3_q <= setup_d;
  end
  assign vld_chain[0] = s3_vld_q;
  assign chain[0] = s3_q;

  // Division chain: each cell adds one quotient bit.
  genvar g;
  generate
    for (g = 0; g < NCells; g++) begin : g_cell
      vtpd_div_cell u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
        .vld_i(vld_chain[g]), .word_i(chain[g]),
        .vld_o(vld_chain[g+1]), .word_o(chain[g+1])
      );
    end
  endgenerate

  // Output register: saturation against the signed limit, then sign.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lim[l] = chain[NCells].neg[l] ? NegLim : PosLim;
      cl[l] = chain[NCells].sat[l] || (chain[NCells].quo[l] > lim[l]);
      qq[l] = cl[l] ? lim[l] : chain[NCells].quo[l];
      res[l] = chain[NCells].neg[l] ? -qq[l] : qq[l];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vld_chain[NCells];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= res[0]; oy_q <= res[1]; ozz_q <= res[2];
      oz_q <= chain[NCells].wz; oc_q <= |cl;
    end
  end
  assign out_valid_o = ov_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = ozz_q;
  assign w_zero_o = oz_q;
  assign clipped_o = oc_q;

  `VTPD_ASSERT_IMP(a_wz_clip, clk_i, rst_ni, out_valid_o && w_zero_o, clipped_o)
  `VTPD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `VTPD_ASSERT_NEXT(a_keep, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_x_o))
  `VTPD_ASSERT_IMP(a_stall, clk_i, rst_ni, in_stall_o, out_valid_o)
endmodule
`default_nettype wire

FILE: rtl/vtpd_div_cell.sv
// One restoring-division cell: produces one quotient bit for three lanes.
`default_nettype none
module vtpd_div_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                vld_i,
  input  wire vtpd_pkg::div_word_t word_i,
  output logic                     vld_o,
  output vtpd_pkg::div_word_t      word_o
);
  import vtpd_pkg::*;
  div_word_t word_d, word_q;
  logic vld_q;
  logic [MagW:0] shl [3];
  logic [MagW+1:0] trial [3];

  // Bring in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    word_d = word_i;
    for (int l = 0; l < 3; l++) begin
      shl[l] = {word_i.rem[l], word_i.quo[l][QuoW-1]};
      trial[l] = {1'b0, shl[l]} - {2'b00, word_i.den};
      word_d.rem[l] = trial[l][MagW+1] ? shl[l][MagW-1:0] : trial[l][MagW-1:0];
      word_d.quo[l] = {word_i.quo[l][QuoW-2:0], ~trial[l][MagW+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end
  assign vld_o = vld_q;
  assign word_o = word_q;
endmodule
`default_nettype wire

FILE: test/vtpd_checker.sv
// Checker that predicts and compares the results of the vertex transform.
`timescale 1ns / 1ps
module vtpd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic [1:0]         row_i,
  input  logic signed [31:0] v0_i,
  input  logic signed [31:0] v1_i,
  input  logic signed [31:0] v2_i,
  input  logic signed [31:0] v3_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  input  logic               w_zero_i,
  input  logic               clipped_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import vtpd_pkg::*;

  localparam int Frac = 16;
  localparam logic signed [127:0] PosLim = 128'sh7fff_ffff;
  localparam logic signed [127:0] NegLim = -128'sh8000_0000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        clip;
  } vertex_t;

  logic signed [31:0] matrix [16];
  vertex_t            projected_q[$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = projected_q.size();

  // One column of [x y z 1] * M, products floored back to the fraction width.
  function automatic logic signed [63:0] column_sum(input logic signed [63:0] pt[3],
                                                    input int c);
    logic signed [63:0] s;
    logic signed [63:0] m;
    s = matrix[12 + c];
    for (int r = 0; r < 3; r++) begin
      m = matrix[4 * r + c];
      s += (pt[r] * m) >>> Frac;
    end
    return s;
  endfunction

  // Saturating fixed-point quotient; sets clip when it saturates.
  function automatic logic [31:0] scaled_quotient(input logic signed [63:0] num,
                                                  input logic signed [63:0] den,
                                                  inout logic clip);
    logic signed [127:0] n;
    logic signed [127:0] q;
    if (den == 0) begin
      clip = 1'b1;
      return (num < 0) ? NegLim[31:0] : PosLim[31:0];
    end
    n = num;
    n = n <<< Frac;
    q = n / 128'(den);
    if (q > PosLim) begin
      clip = 1'b1;
      q = PosLim;
    end else if (q < NegLim) begin
      clip = 1'b1;
      q = NegLim;
    end
    return q[31:0];
  endfunction

  function automatic vertex_t project(input logic signed [31:0] x, input logic signed [31:0] y,
                                      input logic signed [31:0] z);
    logic signed [63:0] pt[3];
    logic signed [63:0] w;
    vertex_t v;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    w = column_sum(pt, 3);
    v.clip = 1'b0;
    v.x = scaled_quotient(column_sum(pt, 0), w, v.clip);
    v.y = scaled_quotient(column_sum(pt, 1), w, v.clip);
    v.z = scaled_quotient(column_sum(pt, 2), w, v.clip);
    v.wz = (w == 0);
    return v;
  endfunction

  // Accepted input words update the matrix or queue a predicted vertex.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix[i] <= (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
      projected_q.delete();
    end else if (in_valid_i && !in_stall_i) begin
      if (action_i == ActLoad) begin
        matrix[{row_i, 2'd0}] <= v0_i;
        matrix[{row_i, 2'd1}] <= v1_i;
        matrix[{row_i, 2'd2}] <= v2_i;
        matrix[{row_i, 2'd3}] <= v3_i;
      end else begin
        projected_q.push_back(project(v0_i, v1_i, v2_i));
      end
    end
  end

  // Accepted output words are compared with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      fails = 0;
    end else if (out_valid_i && !out_stall_i) begin
      if (projected_q.size() == 0) begin
        $error("output word with no vertex expected");
        fails++;
      end else begin
        e = projected_q.pop_front();
        if (out_x_i !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x_i);
          fails++;
        end
        if (out_y_i !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y_i);
          fails++;
        end
        if (out_z_i !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z_i);
          fails++;
        end
        if (w_zero_i !== e.wz) begin
          $error("w_zero expected %b actual %b", e.wz, w_zero_i);
          fails++;
        end
        if (clipped_i !== e.clip) begin
          $error("clipped expected %b actual %b", e.clip, clipped_i);
          fails++;
        end
      end
    end
  end
endmodule

FILE: test/tb_vertex_transform_perspective_divide.sv
// Testbench top: stimulus and verdict for the vertex transform.
`timescale 1ns / 1ps
module tb_vertex_transform_perspective_divide;
  import vtpd_pkg::*;

  localparam logic signed [31:0] One = 32'sh0001_0000;
  localparam logic signed [31:0] MaxV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinV = 32'sh8000_0000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic action_i;
  logic [1:0] row_i;
  logic signed [31:0] v0_i, v1_i, v2_i, v3_i;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic w_zero_o, clipped_o;
  int fail_count, pending;
  int cycle_count;
  logic hold_req;

  vertex_transform_perspective_divide dut (.*);

  vtpd_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .row_i,
    .v0_i, .v1_i, .v2_i, .v3_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o), .w_zero_i(w_zero_o),
    .clipped_i(clipped_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic act, input logic [1:0] r, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
    action_i   <= act;
    row_i      <= r;
    v0_i       <= a;
    v1_i       <= b;
    v2_i       <= c;
    v3_i       <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Mostly small coordinates, sometimes full range, extremes or zero.
  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? MaxV : MinV;
      3:       return 32'h0;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  // Receiver stalls at random, holds off long once on request, and
  // sometimes stalls on a fixed pattern.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ((cycle_count % 2000) > 1400) begin
        out_stall_i <= (cycle_count % 7) < 2;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    bit drained;
    drained     = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ActLoad;
    row_i       = 2'd0;
    v0_i        = '0;
    v1_i        = '0;
    v2_i        = '0;
    v3_i        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix after reset: the extremes pass straight through.
    send_word(ActXform, 2'd3, MaxV, MinV, 32'h0, MinV);
    send_word(ActXform, 2'd0, MinV, MaxV, One, MaxV);
    send_word(ActXform, 2'd1, 32'hffff_ffff, 32'h1, -One, 32'h0);
    // Perspective: w = x + 1, so x = -1 gives zero w.
    send_word(ActLoad, 2'd0, One, 32'h0, 32'h0, One);
    send_word(ActXform, 2'd2, -One, 32'sh0003_0000, -32'sh0002_0000, 32'h0);
    send_word(ActXform, 2'd0, -One, 32'h0, 32'h0, 32'h0);
    send_word(ActXform, 2'd0, 32'sh0001_8000, One, MaxV, 32'h0);
    // Tiny w clips the large quotients.
    send_word(ActLoad, 2'd0, One, 32'h0, 32'h0, 32'h0);
    send_word(ActLoad, 2'd3, 32'h0, 32'h0, 32'h0, 32'h1);
    send_word(ActXform, 2'd1, MaxV, MinV, 32'sh0000_0001, 32'h0);
    send_word(ActXform, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    // All-zero last column: w is zero for every point.
    send_word(ActLoad, 2'd3, MaxV, MinV, 32'h0, 32'h0);
    send_word(ActXform, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(ActXform, 2'd0, -One, One, One, 32'h0);
    // Full-range rows.
    send_word(ActLoad, 2'd1, MinV, MaxV, MinV, MaxV);
    send_word(ActLoad, 2'd2, MaxV, MinV, MaxV, MinV);
    send_word(ActLoad, 2'd3, One, MinV, MaxV, -One);
    send_word(ActXform, 2'd0, MaxV, MaxV, MaxV, 32'h0);
    send_word(ActXform, 2'd0, MinV, MinV, MinV, 32'h0);
    // Back to identity.
    for (int r = 0; r < 4; r++)
      send_word(ActLoad, r[1:0], (r == 0) ? One : 0, (r == 1) ? One : 0,
                (r == 2) ? One : 0, (r == 3) ? One : 0);

    // Random bursts: mostly points against a slowly changing matrix.
    for (int n = 0; n < 800; ) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++) begin
        if ($urandom_range(0, 9) == 0) begin
          logic [1:0] r;
          r = 2'($urandom_range(0, 3));
          send_word(ActLoad, r, rand_fix(), rand_fix(), rand_fix(),
                    ($urandom_range(0, 2) == 0) ? rand_fix() : ((r == 3) ? One : 0));
        end else begin
          send_word(ActXform, 2'($urandom_range(0, 3)), rand_fix(), rand_fix(), rand_fix(),
                    $urandom());
        end
      end
      // Ask the receiver for one long hold while words keep coming.
      if (n > 200 && !hold_req) hold_req <= 1'b1;
      if (n > 400 && !drained) begin
        // Drain completely once before going on.
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) $display("tb_vertex_transform_perspective_divide: clean");
    else $display("tb_vertex_transform_perspective_divide: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_vertex_transform_perspective_divide: errors");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/vtpd_pkg.sv
rtl/vtpd_div_cell.sv
rtl/vertex_transform_perspective_divide.sv
test/vtpd_checker.sv
test/tb_vertex_transform_perspective_divide.sv
